/* design/dtsg_pkg.sv */
// ----------------------------------------------------------------------------
// dtsg_pkg: DTMF square tone generator package
// Shared types, keypad and tone constants, and the sine table builder.
// ----------------------------------------------------------------------------
package dtsg_pkg;

    // Sample rate, phase accumulator width and sine table size.
    localparam int SAMPLE_RATE_HZ = 10000;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_DEPTH     = 1024;
    localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);

    // Tone length register.
    localparam int              TONE_BITS        = 16;
    localparam logic [TONE_BITS-1:0] TONE_TICKS_RESET = 16'd2000;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Pi in Q28 and the peak sample magnitude.
    localparam longint unsigned PI_Q28   = 64'd843314857;
    localparam longint unsigned SINE_AMP = 64'd2047;

    // Operation codes of a request.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_op        op;
        logic       key_ok;
        logic [1:0] row_sel;
        logic [1:0] col_sel;
    } t_cmd;

    typedef logic [7:0]            t_keypad [16];
    typedef logic [PHASE_BITS-1:0] t_step_tab [4];
    typedef logic signed [11:0]    t_sine_rom [SINE_DEPTH];

    // Keypad in row-major order: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
    localparam t_keypad KEYPAD = '{
        8'h31, 8'h32, 8'h33, 8'h41,
        8'h34, 8'h35, 8'h36, 8'h42,
        8'h37, 8'h38, 8'h39, 8'h43,
        8'h2A, 8'h30, 8'h23, 8'h44
    };

    // Unsigned long division by shift and subtract; used only while the
    // constant tables are built.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Phase increment for a tone, rounded to nearest.
    function automatic logic [PHASE_BITS-1:0] phase_step(input longint unsigned hz);
        longint unsigned num;
        num = (hz << PHASE_BITS) + longint'(SAMPLE_RATE_HZ / 2);
        return PHASE_BITS'(udiv(num, 64'(SAMPLE_RATE_HZ)));
    endfunction

    localparam t_step_tab ROW_STEP = '{
        phase_step(64'd697), phase_step(64'd770), phase_step(64'd852), phase_step(64'd941)
    };
    localparam t_step_tab COL_STEP = '{
        phase_step(64'd1209), phase_step(64'd1336), phase_step(64'd1477), phase_step(64'd1633)
    };

    // One sine sample: Q28 Taylor series, scaled to a signed 12-bit value.
    function automatic logic signed [11:0] sine_entry(input longint unsigned k);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned mag;
        longint unsigned div;
        logic            neg;
        a   = (2 * PI_Q28 * k + longint'(SINE_DEPTH / 2)) >> SINE_IDX_BITS;
        neg = 1'b0;
        if (a >= PI_Q28) begin
            a   = a - PI_Q28;
            neg = 1'b1;
        end
        if (a > PI_Q28) begin
            a = PI_Q28;
        end
        if (2 * a > PI_Q28) begin
            a = PI_Q28 - a;
        end
        a2   = (a * a) >> 28;
        term = a;
        s    = a;
        for (int n = 1; n <= 6; n++) begin
            div  = longint'((2 * n) * (2 * n + 1));
            term = udiv((term * a2) >> 28, div);
            if ((n & 1) == 1) begin
                s = (s >= term) ? s - term : 64'd0;
            end else begin
                s = s + term;
            end
        end
        mag = (s * SINE_AMP + (64'd1 << 27)) >> 28;
        if (mag > SINE_AMP) begin
            mag = SINE_AMP;
        end
        return neg ? -$signed(12'(mag)) : $signed(12'(mag));
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = sine_entry(longint'(k));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

/* design/dtsg_req_if.sv */
// ----------------------------------------------------------------------------
// dtsg_req_if: request channel
// Carries tick and start requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtsg_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] key_code;

    modport source (output valid, output operation, output key_code, input ready);
    modport sink   (input valid, input operation, input key_code, output ready);
endinterface

/* design/dtsg_rsp_if.sv */
// ----------------------------------------------------------------------------
// dtsg_rsp_if: result channel
// Carries one result per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtsg_rsp_if;
    logic valid;
    logic ready;
    logic tone_out;
    logic busy_res;
    logic key_accepted;

    modport source (output valid, output tone_out, output busy_res, output key_accepted,
                    input ready);
    modport sink   (input valid, input tone_out, input busy_res, input key_accepted,
                    output ready);
endinterface

/* design/dtsg_front.sv */
// ----------------------------------------------------------------------------
// dtsg_front: request decoder
// Accepts requests and looks the key up in the keypad to form a command.
// ----------------------------------------------------------------------------
module dtsg_front (
    dtsg_req_if.sink       i_req,
    input  logic           i_queue_full,
    output logic           o_push,
    output dtsg_pkg::t_cmd o_cmd
);
    import dtsg_pkg::*;

    logic       key_hit;
    logic [3:0] key_pos;

    // Keypad search; every key appears once, so at most one entry matches.
    always_comb begin
        key_hit = 1'b0;
        key_pos = '0;
        for (int i = 0; i < 16; i++) begin
            if (KEYPAD[i] == i_req.key_code) begin
                key_hit = 1'b1;
                key_pos = 4'(i);
            end
        end
    end

    // A request is taken whenever the queue has room.
    assign i_req.ready = !i_queue_full;
    assign o_push      = i_req.valid && !i_queue_full;

    // Classified command.
    always_comb begin
        o_cmd.op      = t_op'(i_req.operation);
        o_cmd.key_ok  = key_hit;
        o_cmd.row_sel = key_pos[3:2];
        o_cmd.col_sel = key_pos[1:0];
    end
endmodule

/* design/dtsg_queue.sv */
// ----------------------------------------------------------------------------
// dtsg_queue: command queue
// Small FIFO between the decoder and the tone engine.
// ----------------------------------------------------------------------------
module dtsg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dtsg_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dtsg_pkg::t_cmd o_cmd
);
    import dtsg_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

/* design/dtsg_back.sv */
// ----------------------------------------------------------------------------
// dtsg_back: tone engine
// Runs commands against the tone state, reads the sine table and forms results.
// ----------------------------------------------------------------------------
module dtsg_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtsg_pkg::TONE_BITS-1:0] i_cfg_data,
    input  logic                           i_empty,
    input  dtsg_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    dtsg_rsp_if.source                     o_rsp
);
    import dtsg_pkg::*;

    // Tone state.
    logic [TONE_BITS-1:0]  r_tone_ticks;
    logic [PHASE_BITS-1:0] r_row_phase;
    logic [PHASE_BITS-1:0] r_col_phase;
    logic [1:0]            r_row_sel;
    logic [1:0]            r_col_sel;
    logic [TONE_BITS-1:0]  r_ticks_left;
    logic                  r_playing;
    logic [PHASE_BITS-1:0] n_row_phase;
    logic [PHASE_BITS-1:0] n_col_phase;
    logic [1:0]            n_row_sel;
    logic [1:0]            n_col_sel;
    logic [TONE_BITS-1:0]  n_ticks_left;
    logic                  n_playing;

    // Table read stage.
    logic                  r_s2_valid;
    logic                  r_s2_sample;
    logic                  r_s2_busy;
    logic                  r_s2_acc;
    logic signed [11:0]    r_row_sine;
    logic signed [11:0]    r_col_sine;
    logic                  n_sample;
    logic                  n_busy;
    logic                  n_acc;

    // Output stage.
    logic                  r_out_valid;
    logic                  r_tone;
    logic                  r_busy;
    logic                  r_acc;

    logic                  s3_free;
    logic                  s2_free;
    logic                  s2_move;
    logic signed [12:0]    sine_sum;
    logic [TONE_BITS-1:0]  ticks_dec;

    assign s3_free = !r_out_valid || o_rsp.ready;
    assign s2_move = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s3_free;
    assign o_pop   = !i_empty && s2_free;

    assign ticks_dec = (r_ticks_left != '0) ? r_ticks_left - 1'b1 : r_ticks_left;

    // Command execution against the tone state.
    always_comb begin
        n_row_phase  = r_row_phase;
        n_col_phase  = r_col_phase;
        n_row_sel    = r_row_sel;
        n_col_sel    = r_col_sel;
        n_ticks_left = r_ticks_left;
        n_playing    = r_playing;
        n_sample     = 1'b0;
        n_busy       = r_playing;
        n_acc        = 1'b0;
        case (i_cmd.op)
            OP_START: begin
                if (!r_playing && i_cmd.key_ok) begin
                    n_row_sel    = i_cmd.row_sel;
                    n_col_sel    = i_cmd.col_sel;
                    n_row_phase  = '0;
                    n_col_phase  = '0;
                    n_ticks_left = (r_tone_ticks == '0) ? TONE_BITS'(1) : r_tone_ticks;
                    n_playing    = 1'b1;
                    n_busy       = 1'b1;
                    n_acc        = 1'b1;
                end
            end
            OP_TICK: begin
                if (r_playing) begin
                    n_sample     = 1'b1;
                    n_row_phase  = r_row_phase + ROW_STEP[r_row_sel];
                    n_col_phase  = r_col_phase + COL_STEP[r_col_sel];
                    n_ticks_left = ticks_dec;
                    n_playing    = (ticks_dec != '0);
                end
            end
            default: begin
                n_busy = r_playing;
            end
        endcase
    end

    // Configuration register and tone state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_ticks <= TONE_TICKS_RESET;
            r_row_phase  <= '0;
            r_col_phase  <= '0;
            r_row_sel    <= '0;
            r_col_sel    <= '0;
            r_ticks_left <= '0;
            r_playing    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tone_ticks <= i_cfg_data;
            end
            if (o_pop) begin
                r_row_phase  <= n_row_phase;
                r_col_phase  <= n_col_phase;
                r_row_sel    <= n_row_sel;
                r_col_sel    <= n_col_sel;
                r_ticks_left <= n_ticks_left;
                r_playing    <= n_playing;
            end
        end
    end

    // Sine table reads at the phases before the advance.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row_sine <= SINE_ROM[r_row_phase[PHASE_BITS-1 -: SINE_IDX_BITS]];
            r_col_sine <= SINE_ROM[r_col_phase[PHASE_BITS-1 -: SINE_IDX_BITS]];
            r_s2_sample <= n_sample;
            r_s2_busy   <= n_busy;
            r_s2_acc    <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= o_pop;
        end
    end

    // Output register: square level from the sign of the sine sum.
    assign sine_sum = 13'(r_row_sine) + 13'(r_col_sine);

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_tone <= r_s2_sample && (sine_sum > 13'sd0);
            r_busy <= r_s2_busy;
            r_acc  <= r_s2_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_free) begin
            r_out_valid <= s2_move;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.tone_out     = r_tone;
    assign o_rsp.busy_res     = r_busy;
    assign o_rsp.key_accepted = r_acc;
endmodule

/* design/dtsg_queue_wrap_note.sv */
// ----------------------------------------------------------------------------
// dtsg_cmd_route: command hand-over
// Joins the decoder, the command queue and the tone engine.
// ----------------------------------------------------------------------------
module dtsg_cmd_route (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtsg_pkg::TONE_BITS-1:0] i_cfg_data,
    dtsg_req_if.sink                       i_req,
    dtsg_rsp_if.source                     o_rsp
);
    import dtsg_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // Decode requests into commands.
    dtsg_front u_front (
        .i_req        (i_req),
        .i_queue_full (full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // Buffer commands so decoder and engine stall independently.
    dtsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    // Execute commands and produce results.
    dtsg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_cmd      (queue_cmd),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );
endmodule

/* design/dtmf_square_tone_generator.sv */
// ----------------------------------------------------------------------------
// dtmf_square_tone_generator: DTMF square tone generator
// Plays the two-tone DTMF pair of a keypad key as a one-bit square level.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per handshake: operation 1 starts a tone for the
//   ASCII key in key_code, operation 0 is one sample tick. Every request gives
//   exactly one result on o_rsp: tone_out is the output level for a tick,
//   busy_res tells whether a tone is playing, key_accepted marks a start that
//   began a tone. Unknown keys and starts during a tone are ignored.
//   i_cfg_we with i_cfg_data sets the tone length in ticks (reset 2000); write
//   it only while no request is outstanding.
//   Pipeline: a request passes the queue entry, command execution with sine
//   table read and the output register before its result is valid on o_rsp.
//   Throughput: one request per cycle while o_rsp does not stall, set by the
//   phase update and the two-port registered sine table read.
//   When o_rsp stalls, the engine holds its pipeline and the four-entry command
//   queue keeps taking requests until it fills; then i_req.ready drops.
//   Reset clears the tone state and the queue and loads the default length.
// ----------------------------------------------------------------------------
module dtmf_square_tone_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtsg_pkg::TONE_BITS-1:0] i_cfg_data,
    dtsg_req_if.sink                       i_req,
    dtsg_rsp_if.source                     o_rsp
);
    import dtsg_pkg::*;

    // Front, queue and engine.
    dtsg_cmd_route u_route (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );
endmodule
